// File: sv/ipi_pkg.sv
package ipi_pkg;

  localparam int RegW = 5;
  localparam int TagW = 16;
  localparam int SrcCntW = 2;
  localparam int LatInW = 5;
  // Wide enough for any latency limit the block supports.
  localparam int LatWideW = 7;

  localparam int RegisterCountDef = 32;
  localparam int MaxLatencyDef = 16;

endpackage

// File: sv/ipi_scoreboard.sv
module ipi_scoreboard #(
  parameter int REGISTER_COUNT = ipi_pkg::RegisterCountDef
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      upd_en,
  input  logic                      set_en,
  input  logic [ipi_pkg::RegW-1:0]  set_reg,
  input  logic                      clr_en,
  input  logic [ipi_pkg::RegW-1:0]  clr_reg,
  input  logic [ipi_pkg::RegW-1:0]  look_a,
  input  logic [ipi_pkg::RegW-1:0]  look_b,
  output logic                      pend_a,
  output logic                      pend_b
);

  logic [REGISTER_COUNT-1:0] reg_ready;
  logic [REGISTER_COUNT-1:0] set_oh;
  logic [REGISTER_COUNT-1:0] clr_oh;
  logic [REGISTER_COUNT-1:0] sel_a;
  logic [REGISTER_COUNT-1:0] sel_b;
  logic [REGISTER_COUNT-1:0] ready_eff;

  // Register numbers beyond the file match no entry, so they read as ready
  // and their updates fall away.
  always_comb begin
    for (int i = 0; i < REGISTER_COUNT; i++) begin
      set_oh[i] = set_en && (32'(set_reg) == 32'(i));
      clr_oh[i] = clr_en && (32'(clr_reg) == 32'(i));
      sel_a[i]  = (32'(look_a) == 32'(i));
      sel_b[i]  = (32'(look_b) == 32'(i));
    end
  end

  // Writeback frees its register before decode looks at the sources.
  assign ready_eff = reg_ready | set_oh;
  assign pend_a    = |(sel_a & ~ready_eff);
  assign pend_b    = |(sel_b & ~ready_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_ready <= '1;
    end else if (upd_en) begin
      reg_ready <= ready_eff & ~clr_oh;
    end
  end

endmodule

// File: sv/inorder_pipeline_interlock_core.sv
// In-order five-stage pipeline model with a register scoreboard.
// Each input item is one pipeline clock: it offers the next trace
// instruction (or, with instr_present low, the end of the trace). Each item
// gives exactly one result: whether the offered instruction was fetched
// (if not, offer it again in a later item), any retirement at writeback with
// its tag, data and control hazard pulses, and the sticky run_finished flag.
// Both channels use valid/ready. An accepted item is held in an input
// register; the pipeline clock is evaluated from it into the result
// register, which holds the result until the receiver takes it. One item is
// taken every cycle while the receiver keeps up.
// If the receiver stalls, the result register holds its result, the input
// register keeps one more item and then in_ready falls; no item is lost.
// Reset empties all stages, marks every register ready, rewinds the
// execute counter to one and clears the finished flag behind run_finished.
module inorder_pipeline_interlock_core #(
  parameter int REGISTER_COUNT = ipi_pkg::RegisterCountDef,
  parameter int MAX_LATENCY    = ipi_pkg::MaxLatencyDef
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         instr_present,
  input  logic [ipi_pkg::TagW-1:0]     instr_tag,
  input  logic [ipi_pkg::SrcCntW-1:0]  source_count,
  input  logic [ipi_pkg::RegW-1:0]     source_a,
  input  logic [ipi_pkg::RegW-1:0]     source_b,
  input  logic                         dest_present,
  input  logic [ipi_pkg::RegW-1:0]     dest_reg,
  input  logic                         is_control,
  input  logic [ipi_pkg::LatInW-1:0]   exec_cycles,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         fetch_taken,
  output logic                         retire_valid,
  output logic [ipi_pkg::TagW-1:0]     retire_tag,
  output logic                         data_hazard,
  output logic                         control_hazard,
  output logic                         run_finished
);

  localparam int LatW = $clog2(MAX_LATENCY + 1);

  typedef struct packed {
    logic                        valid;
    logic [ipi_pkg::TagW-1:0]    tag;
    logic [ipi_pkg::SrcCntW-1:0] nsrc;
    logic [ipi_pkg::RegW-1:0]    srca;
    logic [ipi_pkg::RegW-1:0]    srcb;
    logic                        has_dest;
    logic [ipi_pkg::RegW-1:0]    dest;
    logic                        ctrl;
    logic [LatW-1:0]             lat;
  } front_slot_t;

  typedef struct packed {
    logic                     valid;
    logic [ipi_pkg::TagW-1:0] tag;
    logic                     has_dest;
    logic [ipi_pkg::RegW-1:0] dest;
    logic                     ctrl;
  } back_slot_t;

  // Input register
  logic                        ir_valid;
  logic                        ir_present;
  logic [ipi_pkg::TagW-1:0]    ir_tag;
  logic [ipi_pkg::SrcCntW-1:0] ir_nsrc;
  logic [ipi_pkg::RegW-1:0]    ir_srca;
  logic [ipi_pkg::RegW-1:0]    ir_srcb;
  logic                        ir_has_dest;
  logic [ipi_pkg::RegW-1:0]    ir_dest;
  logic                        ir_ctrl;
  logic [ipi_pkg::LatInW-1:0]  ir_lat;

  // Pipeline state
  front_slot_t     fe;
  front_slot_t     dc;
  back_slot_t      ex;
  back_slot_t      mem;
  logic [LatW-1:0] exec_elapsed;
  logic            exec_busy;
  logic            decode_stall;
  logic            control_stall;
  logic            trace_more;
  logic            finished;

  front_slot_t     fe_next;
  front_slot_t     dc_next;
  back_slot_t      ex_next;
  logic [LatW-1:0] exec_elapsed_next;
  logic            exec_busy_next;
  logic            decode_stall_next;
  logic            control_stall_next;
  logic            trace_more_next;
  logic            finished_next;

  logic                     taken_c;
  logic                     retire_c;
  logic [ipi_pkg::TagW-1:0] rtag_c;
  logic                     dhaz_c;
  logic                     chaz_c;

  logic                         step_en;
  logic                         pend_a;
  logic                         pend_b;
  logic                         src_wait;
  logic                         sb_set_en;
  logic [ipi_pkg::RegW-1:0]     sb_set_reg;
  logic                         sb_clr_en;
  logic [ipi_pkg::RegW-1:0]     sb_clr_reg;
  logic [ipi_pkg::LatWideW-1:0] lat_wide;

  assign step_en  = ir_valid && (!out_valid || out_ready);
  assign in_ready = !ir_valid || step_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_ready) begin
      ir_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      ir_present  <= instr_present;
      ir_tag      <= instr_tag;
      ir_nsrc     <= source_count;
      ir_srca     <= source_a;
      ir_srcb     <= source_b;
      ir_has_dest <= dest_present;
      ir_dest     <= dest_reg;
      ir_ctrl     <= is_control;
      ir_lat      <= exec_cycles;
    end
  end

  // Writeback frees the destination of the retiring instruction.
  assign sb_set_en  = mem.valid && mem.has_dest;
  assign sb_set_reg = mem.dest;

  ipi_scoreboard #(
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_scoreboard (
    .clk     (clk),
    .rst     (rst),
    .upd_en  (step_en),
    .set_en  (sb_set_en),
    .set_reg (sb_set_reg),
    .clr_en  (sb_clr_en),
    .clr_reg (sb_clr_reg),
    .look_a  (fe.srca),
    .look_b  (fe.srcb),
    .pend_a  (pend_a),
    .pend_b  (pend_b)
  );

  // A source count of three counts as two.
  assign src_wait = ((fe.nsrc >= 2'd1) && pend_a) ||
                    ((fe.nsrc >= 2'd2) && pend_b);

  always_comb begin
    lat_wide = ipi_pkg::LatWideW'(ir_lat);
    if (lat_wide == '0) begin
      lat_wide = ipi_pkg::LatWideW'(1);
    end else if (lat_wide > ipi_pkg::LatWideW'(MAX_LATENCY)) begin
      lat_wide = ipi_pkg::LatWideW'(MAX_LATENCY);
    end
  end

  // One pipeline clock: writeback, memory, execute, decode, fetch in turn,
  // each later stage seeing what the earlier ones have just done.
  always_comb begin
    fe_next            = fe;
    dc_next            = dc;
    ex_next            = ex;
    exec_elapsed_next  = exec_elapsed;
    exec_busy_next     = exec_busy;
    decode_stall_next  = decode_stall;
    control_stall_next = control_stall;
    trace_more_next    = trace_more;
    taken_c            = 1'b0;
    dhaz_c             = 1'b0;
    chaz_c             = 1'b0;
    sb_clr_en          = 1'b0;
    sb_clr_reg         = '0;

    // Writeback, with the finish check on the stages as they stood.
    finished_next = finished || (!trace_more && !ex.valid && !dc.valid && !fe.valid);
    retire_c      = mem.valid;
    rtag_c        = mem.valid ? mem.tag : '0;
    if (mem.valid) begin
      if (mem.ctrl) begin
        control_stall_next = 1'b0;
      end
    end

    // Execute
    if (!dc.valid) begin
      ex_next.valid = 1'b0;
    end else if (exec_elapsed < dc.lat) begin
      exec_elapsed_next = exec_elapsed + LatW'(1);
      exec_busy_next    = 1'b1;
      ex_next.valid     = 1'b0;
    end else begin
      exec_elapsed_next = LatW'(1);
      exec_busy_next    = 1'b0;
      ex_next.valid     = 1'b1;
      ex_next.tag       = dc.tag;
      ex_next.has_dest  = dc.has_dest;
      ex_next.dest      = dc.dest;
      ex_next.ctrl      = dc.ctrl;
    end

    // Decode
    if (exec_busy_next) begin
      decode_stall_next = 1'b1;
    end else if (!fe.valid) begin
      dc_next.valid     = 1'b0;
      decode_stall_next = 1'b0;
    end else if (src_wait) begin
      decode_stall_next = 1'b1;
      dc_next.valid     = 1'b0;
      dhaz_c            = 1'b1;
      chaz_c            = fe.ctrl;
    end else begin
      if (fe.ctrl) begin
        control_stall_next = 1'b1;
        chaz_c             = 1'b1;
      end
      decode_stall_next = 1'b0;
      sb_clr_en         = fe.has_dest;
      sb_clr_reg        = fe.dest;
      dc_next           = fe;
      dc_next.valid     = 1'b1;
    end

    // Fetch
    if (!control_stall_next && !decode_stall_next) begin
      fe_next.valid    = ir_present;
      fe_next.tag      = ir_tag;
      fe_next.nsrc     = ir_nsrc;
      fe_next.srca     = ir_srca;
      fe_next.srcb     = ir_srcb;
      fe_next.has_dest = ir_has_dest;
      fe_next.dest     = ir_dest;
      fe_next.ctrl     = ir_ctrl;
      fe_next.lat      = LatW'(lat_wide);
      trace_more_next  = ir_present;
      taken_c          = ir_present;
    end else if (control_stall_next) begin
      fe_next.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fe.valid      <= 1'b0;
      dc.valid      <= 1'b0;
      ex.valid      <= 1'b0;
      mem.valid     <= 1'b0;
      exec_elapsed  <= LatW'(1);
      exec_busy     <= 1'b0;
      decode_stall  <= 1'b0;
      control_stall <= 1'b0;
      trace_more    <= 1'b1;
      finished      <= 1'b0;
    end else if (step_en) begin
      fe            <= fe_next;
      dc            <= dc_next;
      ex            <= ex_next;
      mem           <= ex;
      exec_elapsed  <= exec_elapsed_next;
      exec_busy     <= exec_busy_next;
      decode_stall  <= decode_stall_next;
      control_stall <= control_stall_next;
      trace_more    <= trace_more_next;
      finished      <= finished_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= step_en || (out_valid && !out_ready);
    end
    if (step_en) begin
      fetch_taken    <= taken_c;
      retire_valid   <= retire_c;
      retire_tag     <= rtag_c;
      data_hazard    <= dhaz_c;
      control_hazard <= chaz_c;
      run_finished   <= finished_next;
    end
  end

  a_ctrl_stall_drains_fetch: assert property (@(posedge clk) disable iff (rst)
    step_en && control_stall_next |=> !fe.valid)
    else $error("fetch slot filled while a control instruction is in flight");

  a_busy_no_issue: assert property (@(posedge clk) disable iff (rst)
    step_en && exec_busy_next |=> !ex.valid)
    else $error("execute issued while still busy");

  a_taken_fills_fetch: assert property (@(posedge clk) disable iff (rst)
    step_en && taken_c |=> fe.valid)
    else $error("taken instruction missing from fetch slot");

  a_finished_sticky: assert property (@(posedge clk) disable iff (rst)
    finished |=> finished)
    else $error("run finished flag dropped");

  a_elapsed_range: assert property (@(posedge clk) disable iff (rst)
    exec_elapsed != '0 && 32'(exec_elapsed) <= MAX_LATENCY)
    else $error("execute counter out of range");

endmodule
